// ===== rtl/phased_counting_barrier_assert.svh =====
// Assertion macros for the phased counting barrier.
`ifndef PHASED_COUNTING_BARRIER_ASSERT_SVH
`define PHASED_COUNTING_BARRIER_ASSERT_SVH

`ifndef SYNTHESIS
// checked only out of reset
`define PCB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define PCB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define PCB_ASSERT(lbl, prop, msg)
`define PCB_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/pcb_pkg.sv =====
// Shared constants and types of the phased counting barrier.
package pcb_pkg;

    localparam int MAX_PROCS_DEF  = 16;
    localparam int MAX_PHASES_DEF = 8;

    // fixed field widths
    localparam int OPCODE_W    = 2;
    localparam int PROC_ID_W   = 4;
    localparam int ARR_IDX_W   = 4;
    localparam int PH_ARR_W    = 5;
    localparam int PROC_CNT_W  = 5;
    localparam int PHASE_CNT_W = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 5;

    localparam logic [PROC_CNT_W-1:0]  PROC_CNT_RST  = PROC_CNT_W'(16);
    localparam logic [PHASE_CNT_W-1:0] PHASE_CNT_RST = PHASE_CNT_W'(8);

    typedef enum logic [OPCODE_W-1:0] {
        OP_WEAK   = 2'd0,
        OP_STRONG = 2'd1,
        OP_PASS   = 2'd2,
        OP_CHECK  = 2'd3
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROC_COUNT  = 2'd0,
        REG_PHASE_COUNT = 2'd1
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_PH   = 3'b010,
        S_CNT  = 3'b100
    } t_state;

endpackage

// ===== rtl/pcb_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module pcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/phased_counting_barrier.sv =====
// Phased counting barrier: per-processor phase RAM and a ring of arrival counters.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+---------------------------------------------
//  in      | in  | i_in_valid/o_in_stall | opcode, proc_id
//  out     | out | o_out_valid/i_out_stall | arrival_index, phase_arrivals, passed, status
//  cfg     | in  | i_cfg_valid/o_cfg_ready | index, data
//
// A request passes from accept through the phase RAM read, the counter RAM read, then
// update and write back, which also registers the result. A new request is accepted only
// once the previous one has written back; the counter read depends on the phase read.
// Reset and a phase_count write clear both RAMs at once through per-entry valid bits.
// A stalled output holds the finished word; the next request can run up to its
// write-back stage while that word waits.
module phased_counting_barrier
    import pcb_pkg::*;
#(
    parameter int MAX_PROCS  = MAX_PROCS_DEF,
    parameter int MAX_PHASES = MAX_PHASES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [OPCODE_W-1:0]    i_in_opcode,
    input  logic [PROC_ID_W-1:0]   i_in_proc_id,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [ARR_IDX_W-1:0]   o_out_arrival_index,
    output logic [PH_ARR_W-1:0]    o_out_phase_arrivals,
    output logic                   o_out_passed,
    output logic                   o_out_status,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

`include "phased_counting_barrier_assert.svh"

    localparam int PID_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int PH_W  = $clog2(MAX_PHASES);
    localparam int PC_W  = $clog2(MAX_PHASES + 1);
    localparam int CNT_W = $clog2(MAX_PROCS + 1);

    function automatic logic [PC_W-1:0] f_eff_ph(input logic [PHASE_CNT_W-1:0] v);
        logic [PC_W-1:0] r;
        if (int'(v) < 3) begin
            r = PC_W'(3);
        end else if (int'(v) > MAX_PHASES) begin
            r = PC_W'(MAX_PHASES);
        end else begin
            r = PC_W'(v);
        end
        return r;
    endfunction

    // configuration
    logic [PROC_CNT_W-1:0]  r_proc_count;
    logic [PHASE_CNT_W-1:0] r_phase_count;
    logic [CNT_W-1:0]       eff_np;
    logic [PC_W-1:0]        eff_ph;
    logic                   cfg_wr;
    logic                   ring_init;
    logic [PC_W-1:0]        cfg_ph;

    // control and datapath registers
    t_state                 r_state;
    t_opcode                r_op;
    logic [PID_W-1:0]       r_id;
    logic                   r_id_ok;
    logic [PH_W-1:0]        r_cur;
    logic [PH_W-1:0]        r_prev;
    logic [PH_W-1:0]        r_next;
    logic [PH_W-1:0]        r_lu;
    logic [MAX_PROCS-1:0]   r_ph_vld;
    logic [MAX_PHASES-1:0]  r_cnt_vld;

    logic                   r_out_valid;
    logic [ARR_IDX_W-1:0]   r_out_idx;
    logic [PH_ARR_W-1:0]    r_out_arr;
    logic                   r_out_passed;
    logic                   r_out_status;

    // RAM ports
    logic [PH_W-1:0]        ph_rdata;
    logic [CNT_W-1:0]       cnt_rdata;
    logic                   ph_we;
    logic                   cnt_we;
    logic                   cnt_re;
    logic [PH_W-1:0]        cnt_raddr;

    logic                   in_acc;
    logic                   out_free;
    logic                   commit;
    logic [PH_W-1:0]        cur;
    logic [PH_W-1:0]        prev;
    logic [PH_W-1:0]        nxt;
    logic [CNT_W-1:0]       cnt;
    logic                   full;
    logic [MAX_PHASES-1:0]  clr_mask;
    logic [PC_W-1:0]        d_prev;
    logic [PC_W-1:0]        d_e;

    assign cfg_wr    = i_cfg_valid && o_cfg_ready;
    assign ring_init = cfg_wr && (i_cfg_index == REG_PHASE_COUNT);
    assign cfg_ph    = f_eff_ph(PHASE_CNT_W'(i_cfg_data));

    always_comb begin
        if (r_proc_count == '0) begin
            eff_np = CNT_W'(1);
        end else if (int'(r_proc_count) > MAX_PROCS) begin
            eff_np = CNT_W'(MAX_PROCS);
        end else begin
            eff_np = CNT_W'(r_proc_count);
        end
    end

    assign eff_ph = f_eff_ph(r_phase_count);

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign commit   = (r_state == S_CNT) && out_free;

    // phase read: entry never written since init reads as phase 0
    assign cur  = r_ph_vld[r_id] ? ph_rdata : '0;
    assign prev = (cur == '0) ? PH_W'(eff_ph - PC_W'(1)) : PH_W'(cur - PH_W'(1));
    assign nxt  = (PC_W'(cur) == eff_ph - PC_W'(1)) ? '0 : PH_W'(cur + PH_W'(1));

    assign cnt_re    = (r_state == S_PH) && r_id_ok;
    assign cnt_raddr = (r_op == OP_PASS) ? prev : cur;

    assign cnt  = r_cnt_vld[r_cur] ? cnt_rdata : '0;
    assign full = (cnt >= eff_np);

    // counters from last used up to (not incl.) prev, walking the ring
    always_comb begin
        d_prev = (r_prev >= r_lu) ? PC_W'(r_prev - r_lu)
                                  : PC_W'(eff_ph - PC_W'(r_lu - r_prev));
        for (int e = 0; e < MAX_PHASES; e++) begin
            d_e = (PH_W'(e) >= r_lu) ? PC_W'(PH_W'(e) - r_lu)
                                     : PC_W'(eff_ph - PC_W'(r_lu - PH_W'(e)));
            clr_mask[e] = (PC_W'(e) < eff_ph) && (d_e < d_prev);
        end
    end

    assign ph_we  = commit && r_id_ok && (r_op == OP_WEAK || r_op == OP_STRONG);
    assign cnt_we = ph_we && !full;

    pcb_ram #(
        .WIDTH (PH_W),
        .DEPTH (MAX_PROCS)
    ) u_phase_ram (
        .i_clk   (i_clk),
        .i_we    (ph_we),
        .i_waddr (r_id),
        .i_wdata (r_next),
        .i_re    (in_acc),
        .i_raddr (PID_W'(i_in_proc_id)),
        .o_rdata (ph_rdata)
    );

    pcb_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_PHASES)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (r_cur),
        .i_wdata (CNT_W'(cnt + CNT_W'(1))),
        .i_re    (cnt_re),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_proc_count  <= PROC_CNT_RST;
            r_phase_count <= PHASE_CNT_RST;
            r_lu          <= PH_W'(f_eff_ph(PHASE_CNT_RST) - PC_W'(1));
            r_ph_vld      <= '0;
            r_cnt_vld     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (cfg_wr && i_cfg_index == REG_PROC_COUNT) begin
                r_proc_count <= PROC_CNT_W'(i_cfg_data);
            end
            if (ring_init) begin
                r_phase_count <= PHASE_CNT_W'(i_cfg_data);
                r_lu          <= PH_W'(cfg_ph - PC_W'(1));
                r_ph_vld      <= '0;
                r_cnt_vld     <= '0;
            end

            if (r_out_valid && !i_out_stall && !commit) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_PH;
                    end
                end
                S_PH: begin
                    r_state <= S_CNT;
                end
                S_CNT: begin
                    if (commit) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b1;
                        if (ph_we) begin
                            r_ph_vld[r_id] <= 1'b1;
                        end
                        if (cnt_we) begin
                            r_cnt_vld[r_cur] <= 1'b1;
                        end
                        if (r_id_ok && r_op == OP_PASS && full) begin
                            r_cnt_vld <= r_cnt_vld & ~clr_mask;
                            r_lu      <= r_prev;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op    <= t_opcode'(i_in_opcode);
            r_id    <= PID_W'(i_in_proc_id);
            r_id_ok <= (int'(i_in_proc_id) < MAX_PROCS);
        end
        if (r_state == S_PH) begin
            r_cur  <= cnt_raddr;
            r_prev <= prev;
            r_next <= nxt;
        end
        if (commit) begin
            r_out_idx    <= '0;
            r_out_arr    <= '0;
            r_out_passed <= 1'b0;
            r_out_status <= 1'b0;
            if (r_id_ok) begin
                case (r_op)
                    OP_WEAK, OP_STRONG: begin
                        if (full) begin
                            r_out_status <= 1'b1;
                            r_out_arr    <= PH_ARR_W'(cnt);
                        end else begin
                            r_out_idx <= ARR_IDX_W'(cnt);
                            r_out_arr <= PH_ARR_W'(cnt + CNT_W'(1));
                        end
                    end
                    OP_PASS: begin
                        r_out_arr    <= PH_ARR_W'(cnt);
                        r_out_passed <= full;
                    end
                    default: begin
                        r_out_arr <= PH_ARR_W'(cnt);
                    end
                endcase
            end
        end
    end

    assign o_in_stall           = (r_state != S_IDLE);
    assign o_cfg_ready          = 1'b1;
    assign o_out_valid          = r_out_valid;
    assign o_out_arrival_index  = r_out_idx;
    assign o_out_phase_arrivals = r_out_arr;
    assign o_out_passed         = r_out_passed;
    assign o_out_status         = r_out_status;

    `PCB_ASSERT(a_acc_to_read, in_acc |=> (r_state == S_PH), "accepted word did not start a read")
    `PCB_ASSERT(a_lu_in_ring, (PC_W'(r_lu) < eff_ph), "last used phase outside the ring")
    `PCB_ASSERT(a_out_from_update, $rose(o_out_valid) |-> $past(r_state == S_CNT), "result without update")
    `PCB_ASSERT_ALWAYS(a_pass_xor_full, !i_rst_n || !(o_out_valid && o_out_passed && o_out_status), "pass word flagged full")

endmodule
